// ===== design/sidstr_pkg.sv =====
// shared types, constants and helper functions for the signed integer to
// digit string converter
// no dependencies
`default_nettype none

package sidstr_pkg;

    // width of the signed input value
    localparam int VALUE_WIDTH = 32;
    // input word padded to whole bytes
    localparam int S_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;
    // one digit cell per possible base-2 digit
    localparam int NDIG        = VALUE_WIDTH;
    localparam int NDIG_W      = $clog2(NDIG + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    // digit, radix and length fields
    localparam int DIG_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 6;
    localparam int M_DATA_W    = ((CHAR_W + LEN_W + 7) / 8) * 8;

    localparam logic [DIG_W-1:0] RADIX_RESET = DIG_W'(10);
    localparam logic [DIG_W-1:0] RADIX_MIN   = DIG_W'(2);
    localparam logic [DIG_W-1:0] RADIX_MAX   = DIG_W'(36);
    localparam logic [DIG_W-1:0] DEC_MAX     = DIG_W'(9);
    localparam logic [DIG_W-1:0] DEC_BASE    = DIG_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    // configuration register index
    localparam logic REG_RADIX = 1'b0;

    // common controls of the digit cell row
    typedef struct packed {
        logic clr;    // zero every cell
        logic shift;  // move digits one cell toward the top
    } cell_ctrl_t;

    // radix outside 2..36 is clamped
    function automatic logic [DIG_W-1:0] eff_radix(input logic [DIG_W-1:0] r);
        logic [DIG_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // digit value to ascii, lower-case letters above nine
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > DEC_MAX) begin
            res = CHAR_A + CHAR_W'(d - DEC_BASE);
        end else begin
            res = CHAR_ZERO + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/sidstr_cell.sv =====
// one digit cell: doubles its digit and adds the carry from below, reducing
// modulo the radix; carry and enable are registered toward the next cell
// depends on sidstr_pkg
`default_nettype none

module sidstr_cell
    import sidstr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [DIG_W-1:0] radix,
    input  wire logic             en_in,
    input  wire logic             carry_in,
    input  wire logic [DIG_W-1:0] digit_in,
    output logic      [DIG_W-1:0] digit,
    output logic                  carry,
    output logic                  en
);

    logic [DIG_W-1:0] digit_reg, digit_next;
    logic             carry_reg, carry_next;
    logic             en_reg, en_next;
    logic [DIG_W:0]   dbl;
    logic [DIG_W:0]   diff;
    logic             ge;

    // doubled digit plus incoming carry, below twice the radix
    assign dbl  = {digit_reg, 1'b0} + {{DIG_W{1'b0}}, carry_in};
    assign diff = dbl - {1'b0, radix};
    assign ge   = (dbl >= {1'b0, radix});

    // next state of the cell
    always_comb begin
        digit_next = digit_reg;
        carry_next = 1'b0;
        en_next    = 1'b0;
        if (ctrl.clr) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end else begin
            en_next = en_in;
            if (en_in) begin
                digit_next = ge ? diff[DIG_W-1:0] : dbl[DIG_W-1:0];
                carry_next = ge;
            end
        end
    end

    // control bits reset, digit is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= 1'b0;
            en_reg    <= 1'b0;
        end else begin
            carry_reg <= carry_next;
            en_reg    <= en_next;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;
    assign carry = carry_reg;
    assign en    = en_reg;

endmodule

`default_nettype wire

// ===== design/sidstr_array.sv =====
// row of digit cells; bits enter cell zero msb first and the carry
// wavefront moves one cell per cycle; digits shift out at the top
// depends on sidstr_pkg and sidstr_cell
`default_nettype none

module sidstr_array
    import sidstr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [DIG_W-1:0] radix,
    input  wire logic             feed_en,
    input  wire logic             feed_bit,
    output logic      [DIG_W-1:0] top_digit,
    output logic                  busy
);

    logic [DIG_W-1:0] digit_w [NDIG];
    logic [NDIG-1:0]  carry_w;
    logic [NDIG-1:0]  en_w;

    // cell zero takes the input bit stream
    sidstr_cell u_cell0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .radix    (radix),
        .en_in    (feed_en),
        .carry_in (feed_bit),
        .digit_in ('0),
        .digit    (digit_w[0]),
        .carry    (carry_w[0]),
        .en       (en_w[0])
    );

    // remaining cells chained on the registered carry and enable
    for (genvar k = 1; k < NDIG; k++) begin : g_cell
        sidstr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .radix    (radix),
            .en_in    (en_w[k-1]),
            .carry_in (carry_w[k-1]),
            .digit_in (digit_w[k-1]),
            .digit    (digit_w[k]),
            .carry    (carry_w[k]),
            .en       (en_w[k])
        );
    end

    assign top_digit = digit_w[NDIG-1];
    // the top carry is always zero, it is only watched
    assign busy      = (|en_w) | carry_w[NDIG-1];

endmodule

`default_nettype wire

// ===== design/signed_integer_to_digit_string.sv =====
// Converts a signed VALUE_WIDTH-bit value to ascii text in the programmed
// radix (2..36, clamped), most significant character first, with a leading
// '-' for negative values. Each output word carries the character, the
// total string length and tlast on the final character. One value is taken
// at a time: after acceptance the magnitude is fed msb first into a row of
// VALUE_WIDTH digit cells and the carry wavefront runs up to the top
// cell, leading zero digits are trimmed at one per cycle, then one
// character leaves per cycle while the sink accepts. The next value is
// accepted while the final character still waits in the output register.
// depends on sidstr_pkg and sidstr_array
`default_nettype none

module signed_integer_to_digit_string
    import sidstr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input channel, tdata: value
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // output channel, tdata: character, string_length, zero pad
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tlast,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [DIG_W-1:0]       radix_reg;
    logic [DIG_W-1:0]       rad_eff_reg, rad_eff_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic [NDIG_W-1:0]      rem_reg, rem_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic [LEN_W-1:0]       m_len_reg, m_len_next;
    logic                   m_last_reg, m_last_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_accept;
    logic                   out_free;
    logic                   cfg_write;
    cell_ctrl_t             cell_ctrl;
    logic                   feed_en;
    logic [DIG_W-1:0]       top_digit;
    logic                   arr_busy;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write && (paddr[2] == REG_RADIX)) begin
            radix_reg <= pwdata[DIG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RADIX) begin
            prdata = {{(32-DIG_W){1'b0}}, radix_reg};
        end
    end

    // handshake helpers
    assign in_value  = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign feed_en   = (state_reg == ST_CONV);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rad_eff_next   = rad_eff_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        ndig_next      = ndig_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        sign_pend_next = sign_pend_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_char_next    = m_char_reg;
        m_len_next     = m_len_reg;
        m_last_next    = m_last_reg;
        cell_ctrl      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    neg_next      = in_value[VALUE_WIDTH-1];
                    mag_next      = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
                    rad_eff_next  = eff_radix(radix_reg);
                    bit_cnt_next  = '0;
                    cell_ctrl.clr = 1'b1;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV: begin
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!arr_busy) begin
                    ndig_next  = NDIG_W'(NDIG);
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // trim leading zero digits, keep at least one
                if ((top_digit == '0) && (ndig_reg > NDIG_W'(1))) begin
                    cell_ctrl.shift = 1'b1;
                    ndig_next       = ndig_reg - 1'b1;
                end else begin
                    rem_next       = ndig_reg;
                    len_next       = LEN_W'({1'b0, ndig_reg} + {{NDIG_W{1'b0}}, neg_reg});
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_len_next   = len_reg;
                    if (sign_pend_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_last_next    = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_char_next     = digit_char(top_digit);
                        m_last_next     = (rem_reg == NDIG_W'(1));
                        cell_ctrl.shift = 1'b1;
                        rem_next        = rem_reg - 1'b1;
                        if (rem_reg == NDIG_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            ndig_reg      <= '0;
            rem_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            sign_pend_reg <= sign_pend_next;
            bit_cnt_reg   <= bit_cnt_next;
            ndig_reg      <= ndig_next;
            rem_reg       <= rem_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rad_eff_reg <= rad_eff_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        len_reg     <= len_next;
        m_char_reg  <= m_char_next;
        m_len_reg   <= m_len_next;
        m_last_reg  <= m_last_next;
    end

    // digit cell row
    sidstr_array u_array (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cell_ctrl),
        .radix     (rad_eff_reg),
        .feed_en   (feed_en),
        .feed_bit  (mag_reg[VALUE_WIDTH-1]),
        .top_digit (top_digit),
        .busy      (arr_busy)
    );

    // output word
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W-CHAR_W-LEN_W){1'b0}}, m_len_reg, m_char_reg};

    // checks
    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_CONV))
        else $error("accepted value did not start conversion");

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("emit state with no digits left");

    a_norm_keeps_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NORM) |-> (ndig_reg != '0))
        else $error("digit count fell to zero");

    a_digit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && !sign_pend_reg) |-> (top_digit < rad_eff_reg))
        else $error("emitted digit not below radix");

    a_no_feed_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NORM) |-> !arr_busy)
        else $error("digit trim started before carries settled");

endmodule

`default_nettype wire

// ===== verif/signed_integer_to_digit_string_test.sv =====
// self-checking testbench for signed_integer_to_digit_string: streams signed values
// in, predicts each character word and checks the output stream field by field
// depends on sidstr_pkg and the signed_integer_to_digit_string rtl
module signed_integer_to_digit_string_test
    import sidstr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 600;
    localparam int NUM_PHASES = 15;
    localparam int PHASE_ITEMS = 30;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [2:0] RADIX_ADDR = 3'(4 * REG_RADIX);
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = "0";
    localparam logic [CHAR_W-1:0] ASCII_A     = "a";
    localparam logic [CHAR_W-1:0] ASCII_MINUS = "-";

    // one output character with its string length and end marker
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  total_len;
        logic              is_last;
    } char_word_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic [31:0]   pending_values[$];
    char_word_t    expected_text[$];
    logic [DIG_W-1:0] radix_shadow = RADIX_RESET;
    int unsigned   mismatch_count = 0;
    logic          s_taken = 1'b0;
    int unsigned   tx_hold = 0;
    int unsigned   rx_hold = 0;
    int unsigned   long_stall_req = 0;
    int unsigned   long_stall_done = 0;
    logic          tx_gaps_on = 1'b0;
    logic          rx_stall_on = 1'b0;
    int unsigned   idle_cycles = 0;

    signed_integer_to_digit_string u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] character, [13:8] string_length, [15:14] zero
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // base actually used: below two counts as two, above 36 as 36
    function automatic logic [DIG_W-1:0] base_in_use(input logic [DIG_W-1:0] raw);
        logic [DIG_W-1:0] b;
        b = raw;
        if (raw < RADIX_MIN) begin
            b = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            b = RADIX_MAX;
        end
        return b;
    endfunction

    // text of one value in the current base, pushed as expected words
    function automatic void queue_expected_text(input logic [31:0] value);
        logic [31:0]       mag;
        logic [31:0]       b;
        logic [31:0]       d;
        logic [CHAR_W-1:0] digits[$];
        logic [CHAR_W-1:0] text[$];
        char_word_t        w;
        b = 32'(base_in_use(radix_shadow));
        // unsigned magnitude, so the most negative value is exact
        mag = value[31] ? (~value + 32'd1) : value;
        if (mag == 0) begin
            digits.push_front(ASCII_ZERO);
        end
        while (mag != 0) begin
            d = mag % b;
            if (d > 9) begin
                digits.push_front(ASCII_A + CHAR_W'(d - 10));
            end else begin
                digits.push_front(ASCII_ZERO + CHAR_W'(d));
            end
            mag = mag / b;
        end
        if (value[31]) begin
            text.push_back(ASCII_MINUS);
        end
        foreach (digits[i]) begin
            text.push_back(digits[i]);
        end
        foreach (text[i]) begin
            w.ch        = text[i];
            w.total_len = LEN_W'(text.size());
            w.is_last   = (i == text.size() - 1);
            expected_text.push_back(w);
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        mismatch_count++;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] got,
                                        input logic [7:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s mismatch: expected 0x%02h, got 0x%02h",
                                    name, want, got));
        end
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 120);
    endfunction

    // random value biased toward extremes, small numbers and powers of the base
    function automatic logic [31:0] random_value(input logic [DIG_W-1:0] b);
        logic [63:0] p;
        logic [31:0] v;
        int unsigned k;
        case ($urandom_range(0, 9))
            4: v = $urandom_range(0, 40);
            5: v = ~32'($urandom_range(0, 39));
            6: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h0;
                    default: v = 32'h1;
                endcase
            end
            7: begin
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (p * b <= 64'h7fff_ffff) begin
                        p = p * b;
                    end
                end
                v = 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v + 32'd1;
                end
            end
            8: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // one apb transfer, setup then access
    task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = RADIX_ADDR;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        rdata = prdata;
        if (is_write) begin
            radix_shadow = wdata[DIG_W-1:0];
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_radix_readback();
        logic [31:0] rd;
        apb_transfer(1'b0, 32'h0, rd);
        if (rd[DIG_W-1:0] !== radix_shadow) begin
            note_mismatch($sformatf("radix readback: expected %0d, got %0d",
                                    radix_shadow, rd[DIG_W-1:0]));
        end
    endtask

    task automatic wait_drained();
        while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // input driver: one word per handshake, random gaps between words
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // word still waiting for acceptance
        end else if (tx_hold > 0) begin
            tx_hold--;
            s_tvalid <= 1'b0;
        end else if (pending_values.size() != 0) begin
            s_tdata  <= pending_values.pop_front();
            s_tvalid <= 1'b1;
            tx_hold  = tx_gaps_on ? gap_len() : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // output receiver: random stalls plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (long_stall_done != long_stall_req) begin
            long_stall_done++;
            rx_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_hold = rx_stall_on ? gap_len() : 0;
        end
    end

    // monitor: predict on input acceptance, check each output word
    always @(posedge aclk) begin
        char_word_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            queue_expected_text(s_tdata[31:0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_text.size() == 0) begin
                note_mismatch($sformatf("unexpected word: char 0x%02h len %0d last %0b",
                                        m_tdata[7:0], m_tdata[13:8], m_tlast));
            end else begin
                want = expected_text.pop_front();
                check_field("character", m_tdata[7:0], want.ch);
                check_field("string_length", 8'(m_tdata[13:8]), 8'(want.total_len));
                check_field("last", 8'(m_tlast), 8'(want.is_last));
            end
        end
    end

    // watchdog on cycles without any accepted transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus phases, the base reprogrammed between phases
    initial begin
        logic [DIG_W-1:0] radix_plan[NUM_PHASES];
        logic [31:0]      directed[$];
        logic [31:0]      rd;
        radix_plan = '{6'd10, 6'd2, 6'd36, 6'd0, 6'd63, 6'd16, 6'd1, 6'd37, 6'd8,
                       6'd3, 6'd35, 6'd7, 6'd10, 6'd0, 6'd0};
        radix_plan[13] = DIG_W'($urandom_range(0, 63));
        radix_plan[14] = DIG_W'($urandom_range(0, 63));
        directed = '{32'h0, 32'h1, 32'hffff_ffff, 32'd9, 32'd10, 32'hffff_fff6,
                     32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe,
                     32'd123456789, 32'hc465_3600, 32'h5555_5555, 32'haaaa_aaaa,
                     32'd99, 32'd100};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        check_radix_readback();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // reprogram the base only while nothing is in flight
            if (phase > 0) begin
                repeat (4) @(posedge aclk);
                apb_transfer(1'b1,
                             {26'($urandom_range(0, 32'h03ff_ffff)), radix_plan[phase]},
                             rd);
                check_radix_readback();
            end
            // some phases run with no idling at all
            if (phase % 5 == 2) begin
                tx_gaps_on  = 1'b0;
                rx_stall_on = 1'b0;
            end else begin
                tx_gaps_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            if (phase == 3 || phase == 9) begin
                long_stall_req++;
            end
            if (phase == 0) begin
                foreach (directed[i]) begin
                    pending_values.push_back(directed[i]);
                end
            end
            repeat (PHASE_ITEMS) begin
                pending_values.push_back(random_value(base_in_use(radix_shadow)));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/sidstr_pkg.sv
design/sidstr_cell.sv
design/sidstr_array.sv
design/signed_integer_to_digit_string.sv
verif/signed_integer_to_digit_string_test.sv
